/* rtl/plhs_pkg.sv */
// ----------------------------------------------------------------------------
// plhs_pkg: shared definitions for the PI limiter Heun step controller
// Fixed-point format, register map, item kinds and the microcode program.
// ----------------------------------------------------------------------------
`default_nettype none

package plhs_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 24;
  localparam int STEP_W = 31;
  localparam int KIND_W = 2;
  localparam int USER_W = 3;
  localparam int ADDR_W = 5;
  localparam int PROD_W = 2 * DATA_W;
  localparam int DIV_W  = DATA_W + FRAC_W;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Integral threshold: 0.00001 in the fixed-point format, rounded.
  localparam int KI_EPS_INT = ((1 << FRAC_W) + 50000) / 100000;
  localparam logic signed [DATA_W-1:0] KI_EPS = DATA_W'(KI_EPS_INT);

  localparam logic signed [DATA_W-1:0] KP_RESET      = DATA_W'(1 << FRAC_W);
  localparam logic signed [DATA_W-1:0] KI_RESET      = '0;
  localparam logic signed [DATA_W-1:0] OUT_MAX_RESET = DATA_W'(1 << FRAC_W);
  localparam logic signed [DATA_W-1:0] OUT_MIN_RESET = -DATA_W'(1 << FRAC_W);
  localparam logic [STEP_W-1:0]        STEP_RESET    = STEP_W'(83886);

  typedef enum logic [KIND_W-1:0] {
    KIND_INIT,
    KIND_PRED,
    KIND_CORR,
    KIND_NONE
  } kind_t;

  typedef enum logic [2:0] {
    REG_KP,
    REG_KI,
    REG_OUT_MAX,
    REG_OUT_MIN,
    REG_STEP_SIZE
  } reg_idx_t;

  typedef enum logic [4:0] {
    UOP_NOP,
    UOP_LOAD,
    UOP_MUL_KP,
    UOP_RND_KIN,
    UOP_LIM,
    UOP_CLAMP,
    UOP_MUL_KI,
    UOP_RND_R,
    UOP_ZERO_R,
    UOP_OUT,
    UOP_MEAN,
    UOP_MUL_STEP,
    UOP_RND_ACC,
    UOP_COMMIT_PRED,
    UOP_COMMIT_CORR,
    UOP_DIV_START,
    UOP_DIV_FINISH,
    UOP_SEED,
    UOP_END
  } uop_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_INACTIVE,
    COND_PRED,
    COND_CORR,
    COND_SEED,
    COND_DIV_BUSY,
    COND_OUT_BUSY
  } cond_t;

  localparam int PC_W     = 5;
  localparam int PROG_LEN = 21;

  localparam logic [PC_W-1:0] L_STEP        = PC_W'(0);
  localparam logic [PC_W-1:0] L_ZERO_R      = PC_W'(7);
  localparam logic [PC_W-1:0] L_OUT         = PC_W'(8);
  localparam logic [PC_W-1:0] L_MUL_STEP    = PC_W'(10);
  localparam logic [PC_W-1:0] L_COMMIT_CORR = PC_W'(13);
  localparam logic [PC_W-1:0] L_RETIRE      = PC_W'(14);
  localparam logic [PC_W-1:0] L_INIT        = PC_W'(15);
  localparam logic [PC_W-1:0] L_DIV_WAIT    = PC_W'(17);
  localparam logic [PC_W-1:0] L_SEED        = PC_W'(19);
  localparam logic [PC_W-1:0] L_END         = PC_W'(20);

  typedef struct packed {
    uop_t            uop;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    case (pc)
      5'd0:    c = '{UOP_LOAD,        COND_NEXT,     L_STEP};
      5'd1:    c = '{UOP_MUL_KP,      COND_NEXT,     L_STEP};
      5'd2:    c = '{UOP_RND_KIN,     COND_INACTIVE, L_ZERO_R};
      5'd3:    c = '{UOP_LIM,         COND_NEXT,     L_STEP};
      5'd4:    c = '{UOP_CLAMP,       COND_NEXT,     L_STEP};
      5'd5:    c = '{UOP_MUL_KI,      COND_NEXT,     L_STEP};
      5'd6:    c = '{UOP_RND_R,       COND_ALWAYS,   L_OUT};
      5'd7:    c = '{UOP_ZERO_R,      COND_NEXT,     L_STEP};
      5'd8:    c = '{UOP_OUT,         COND_PRED,     L_MUL_STEP};
      5'd9:    c = '{UOP_MEAN,        COND_NEXT,     L_STEP};
      5'd10:   c = '{UOP_MUL_STEP,    COND_NEXT,     L_STEP};
      5'd11:   c = '{UOP_RND_ACC,     COND_CORR,     L_COMMIT_CORR};
      5'd12:   c = '{UOP_COMMIT_PRED, COND_ALWAYS,   L_RETIRE};
      5'd13:   c = '{UOP_COMMIT_CORR, COND_NEXT,     L_STEP};
      5'd14:   c = '{UOP_END,         COND_OUT_BUSY, L_RETIRE};
      5'd15:   c = '{UOP_NOP,         COND_SEED,     L_SEED};
      5'd16:   c = '{UOP_DIV_START,   COND_NEXT,     L_STEP};
      5'd17:   c = '{UOP_NOP,         COND_DIV_BUSY, L_DIV_WAIT};
      5'd18:   c = '{UOP_DIV_FINISH,  COND_ALWAYS,   L_END};
      5'd19:   c = '{UOP_SEED,        COND_NEXT,     L_STEP};
      5'd20:   c = '{UOP_END,         COND_OUT_BUSY, L_END};
      default: c = '{UOP_END,         COND_OUT_BUSY, L_END};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/pi_limiter_heun_step.sv */
// ----------------------------------------------------------------------------
// pi_limiter_heun_step: PI controller with output limits and anti-windup
// Init, Heun predictor and Heun corrector items in signed Q8.24 fixed point,
// run by a microcoded sequencer over one multiplier and one serial divider.
// ----------------------------------------------------------------------------
// Items enter on the s_ stream and each one gives one result item on the m_
// stream. The kind of an item is in s_tuser[1:0], the keep-start flag of a
// predictor in s_tuser[2] and the value in s_tdata. Gains, limits and the
// time step are to be written over the APB port only while no item is in
// flight; the block itself does not enforce this. A step item runs the
// microcode program over the shared 32x32 multiplier, with a rounding
// step after every product; the result is in m_tdata in the cycle after
// the last step. An init item either seeds the integrator or divides, one
// quotient bit per cycle over 56 bits, and that path clears the integrator.
// s_tready is high while the sequencer is idle, so one item is worked on
// at a time. A result waiting in the output register does not block the
// next item; that item stalls only at its own last step until m_tready.
// Reset empties the sequencer and output register, sets the registers to
// their defaults and clears the integrator state.
// ----------------------------------------------------------------------------
`default_nettype none

module pi_limiter_heun_step (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [plhs_pkg::DATA_W-1:0]       s_tdata,   // value
  input  logic [plhs_pkg::USER_W-1:0]       s_tuser,   // kind[1:0], keep_start[2]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [plhs_pkg::DATA_W-1:0]       m_tdata,   // result
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [plhs_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int DW = plhs_pkg::DATA_W;
  localparam int FW = plhs_pkg::FRAC_W;
  localparam int PW = plhs_pkg::PROD_W;
  localparam int VW = plhs_pkg::DIV_W;

  localparam logic [PW-1:0] LIM_NEG = PW'(1) << (DW - 1);
  localparam logic [PW-1:0] LIM_POS = LIM_NEG - PW'(1);

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] a);
    return a[DW-1] ? DW'(-a) : a;
  endfunction

  function automatic logic signed [DW-1:0] sat_mag(input logic neg,
                                                   input logic [PW-1:0] m);
    logic signed [DW-1:0] r;
    if (neg) begin
      r = (m > LIM_NEG) ? plhs_pkg::SMIN : -m[DW-1:0];
    end else begin
      r = (m > LIM_POS) ? plhs_pkg::SMAX : m[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DW-1:0] qround(input logic [PW-1:0] p,
                                                  input logic neg);
    logic [PW:0] sum;
    sum = {1'b0, p} + ((PW+1)'(1) << (FW - 1));
    return sat_mag(neg, PW'(sum >> FW));
  endfunction

  function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    logic [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? plhs_pkg::SMIN : plhs_pkg::SMAX;
    end
    return s[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] ssub(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    logic [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? plhs_pkg::SMIN : plhs_pkg::SMAX;
    end
    return s[DW-1:0];
  endfunction

  logic signed [DW-1:0]              kp, ki, out_max, out_min;
  logic [plhs_pkg::STEP_W-1:0]       step_size;
  logic signed [DW-1:0]              integ_start, integ_next, pred_rate;

  plhs_pkg::kind_t                   kind;
  logic signed [DW-1:0]              value;
  logic                              keep_start;

  logic                              running;
  logic [plhs_pkg::PC_W-1:0]         pc;
  plhs_pkg::ctrl_t                   ctrl;
  logic                              cond_hit;
  logic                              out_busy;
  logic                              retire;
  logic                              in_accept;
  logic                              cfg_we;

  logic signed [DW-1:0]              x, kin, tmax, tmin, rate, acc, res;
  logic [PW-1:0]                     prod;
  logic                              prod_neg;
  logic [DW-1:0]                     mul_a, mul_b;
  logic                              mul_neg;
  logic signed [DW-1:0]              rounded;
  logic signed [DW-1:0]              x_clamped, rate_frozen, out_lim;

  logic [plhs_pkg::DCNT_W-1:0]       div_cnt;
  logic [DW-1:0]                     div_rem, div_md;
  logic [VW-1:0]                     div_dsh, div_q;
  logic [DW:0]                       div_sh;
  logic                              div_ge;
  logic [DW:0]                       div_half;
  logic [VW:0]                       div_qr;
  logic signed [DW-1:0]              div_res;

  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite && pready;
  assign s_tready  = !running;
  assign in_accept = s_tvalid && s_tready;
  assign out_busy  = m_tvalid && !m_tready;
  assign ctrl      = plhs_pkg::ucode(pc);
  assign retire    = running && (ctrl.uop == plhs_pkg::UOP_END) && !out_busy;

  always_comb begin
    case (plhs_pkg::reg_idx_t'(paddr[4:2]))
      plhs_pkg::REG_KP:        prdata = kp;
      plhs_pkg::REG_KI:        prdata = ki;
      plhs_pkg::REG_OUT_MAX:   prdata = out_max;
      plhs_pkg::REG_OUT_MIN:   prdata = out_min;
      plhs_pkg::REG_STEP_SIZE: prdata = {1'b0, step_size};
      default:                 prdata = '0;
    endcase
  end

  always_comb begin
    case (ctrl.cond)
      plhs_pkg::COND_NEXT:     cond_hit = 1'b0;
      plhs_pkg::COND_ALWAYS:   cond_hit = 1'b1;
      plhs_pkg::COND_INACTIVE: cond_hit = ki < plhs_pkg::KI_EPS;
      plhs_pkg::COND_PRED:     cond_hit = kind == plhs_pkg::KIND_PRED;
      plhs_pkg::COND_CORR:     cond_hit = kind == plhs_pkg::KIND_CORR;
      plhs_pkg::COND_SEED:     cond_hit = ki > plhs_pkg::KI_EPS;
      plhs_pkg::COND_DIV_BUSY: cond_hit = div_cnt != '0;
      plhs_pkg::COND_OUT_BUSY: cond_hit = out_busy;
      default:                 cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    case (ctrl.uop)
      plhs_pkg::UOP_MUL_KI: begin
        mul_a   = mag(ki);
        mul_b   = mag(value);
        mul_neg = ki[DW-1] ^ value[DW-1];
      end
      plhs_pkg::UOP_MUL_STEP: begin
        mul_a   = mag(rate);
        mul_b   = {1'b0, step_size};
        mul_neg = rate[DW-1];
      end
      default: begin
        mul_a   = mag(kp);
        mul_b   = mag(value);
        mul_neg = kp[DW-1] ^ value[DW-1];
      end
    endcase
  end

  assign rounded = qround(prod, prod_neg);

  // The lower bound is applied last, so it wins when the limits cross.
  always_comb begin
    x_clamped = x;
    if (x_clamped > tmax) begin
      x_clamped = tmax;
    end
    if (x_clamped < tmin) begin
      x_clamped = tmin;
    end
  end

  // The integral rate stops while it pushes further into a limit.
  always_comb begin
    rate_frozen = rounded;
    if (rounded > 0 && x >= tmax) begin
      rate_frozen = '0;
    end
    if (rounded < 0 && x <= tmin) begin
      rate_frozen = '0;
    end
  end

  always_comb begin
    out_lim = sadd(kin, x);
    if (out_lim > out_max) begin
      out_lim = out_max;
    end
    if (out_lim < out_min) begin
      out_lim = out_min;
    end
  end

  assign div_sh   = {div_rem, div_dsh[VW-1]};
  assign div_ge   = div_sh >= {1'b0, div_md};
  assign div_half = {1'b0, div_md} - {1'b0, div_rem};
  assign div_qr   = {1'b0, div_q} + (VW+1)'({1'b0, div_rem} >= div_half);

  always_comb begin
    if (kp == '0) begin
      if (value > 0) begin
        div_res = plhs_pkg::SMAX;
      end else if (value < 0) begin
        div_res = plhs_pkg::SMIN;
      end else begin
        div_res = '0;
      end
    end else begin
      div_res = sat_mag(value[DW-1] ^ kp[DW-1], PW'(div_qr));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= 1'b0;
      pc          <= plhs_pkg::L_END;
      m_tvalid    <= 1'b0;
      div_cnt     <= '0;
      kp          <= plhs_pkg::KP_RESET;
      ki          <= plhs_pkg::KI_RESET;
      out_max     <= plhs_pkg::OUT_MAX_RESET;
      out_min     <= plhs_pkg::OUT_MIN_RESET;
      step_size   <= plhs_pkg::STEP_RESET;
      integ_start <= '0;
      integ_next  <= '0;
      pred_rate   <= '0;
    end else begin
      if (cfg_we) begin
        case (plhs_pkg::reg_idx_t'(paddr[4:2]))
          plhs_pkg::REG_KP:        kp        <= pwdata[DW-1:0];
          plhs_pkg::REG_KI:        ki        <= pwdata[DW-1:0];
          plhs_pkg::REG_OUT_MAX:   out_max   <= pwdata[DW-1:0];
          plhs_pkg::REG_OUT_MIN:   out_min   <= pwdata[DW-1:0];
          plhs_pkg::REG_STEP_SIZE: step_size <= pwdata[plhs_pkg::STEP_W-1:0];
          default: begin
          end
        endcase
      end

      if (retire) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (in_accept) begin
        running <= 1'b1;
        case (plhs_pkg::kind_t'(s_tuser[1:0]))
          plhs_pkg::KIND_INIT: pc <= plhs_pkg::L_INIT;
          plhs_pkg::KIND_PRED: pc <= plhs_pkg::L_STEP;
          plhs_pkg::KIND_CORR: pc <= plhs_pkg::L_STEP;
          default:             pc <= plhs_pkg::L_END;
        endcase
      end else if (running) begin
        if (retire) begin
          running <= 1'b0;
        end
        pc <= cond_hit ? ctrl.target : pc + plhs_pkg::PC_W'(1);
      end

      if (running && ctrl.uop == plhs_pkg::UOP_DIV_START) begin
        div_cnt <= plhs_pkg::DCNT_W'(VW);
      end else if (div_cnt != '0) begin
        div_cnt <= div_cnt - plhs_pkg::DCNT_W'(1);
      end

      if (running) begin
        case (ctrl.uop)
          plhs_pkg::UOP_COMMIT_PRED: begin
            integ_start <= x;
            pred_rate   <= rate;
            integ_next  <= sadd(x, acc);
          end
          plhs_pkg::UOP_COMMIT_CORR: begin
            integ_next <= sadd(integ_start, acc);
          end
          plhs_pkg::UOP_DIV_FINISH: begin
            integ_start <= '0;
            integ_next  <= '0;
            pred_rate   <= '0;
          end
          plhs_pkg::UOP_SEED: begin
            integ_start <= value;
            integ_next  <= value;
            pred_rate   <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind       <= plhs_pkg::kind_t'(s_tuser[1:0]);
      value      <= s_tdata;
      keep_start <= s_tuser[2];
      res        <= '0;
    end

    if (retire) begin
      m_tdata <= res;
    end

    if (running) begin
      case (ctrl.uop)
        plhs_pkg::UOP_LOAD: begin
          x <= (kind == plhs_pkg::KIND_PRED && keep_start) ? integ_start : integ_next;
        end
        plhs_pkg::UOP_MUL_KP, plhs_pkg::UOP_MUL_KI, plhs_pkg::UOP_MUL_STEP: begin
          prod     <= PW'(mul_a) * PW'(mul_b);
          prod_neg <= mul_neg;
        end
        plhs_pkg::UOP_RND_KIN: kin  <= rounded;
        plhs_pkg::UOP_LIM: begin
          tmax <= ssub(out_max, kin);
          tmin <= ssub(out_min, kin);
        end
        plhs_pkg::UOP_CLAMP:   x    <= x_clamped;
        plhs_pkg::UOP_RND_R:   rate <= rate_frozen;
        plhs_pkg::UOP_ZERO_R:  rate <= '0;
        plhs_pkg::UOP_OUT:     res  <= out_lim;
        plhs_pkg::UOP_MEAN: begin
          rate <= DW'(({pred_rate[DW-1], pred_rate} + {rate[DW-1], rate}) >> 1);
        end
        plhs_pkg::UOP_RND_ACC:    acc <= rounded;
        plhs_pkg::UOP_DIV_FINISH: res <= div_res;
        default: begin
        end
      endcase
    end

    if (running && ctrl.uop == plhs_pkg::UOP_DIV_START) begin
      div_rem <= '0;
      div_dsh <= {mag(value), {FW{1'b0}}};
      div_q   <= '0;
      div_md  <= mag(kp);
    end else if (div_cnt != '0) begin
      div_rem <= div_ge ? DW'(div_sh - {1'b0, div_md}) : div_sh[DW-1:0];
      div_dsh <= {div_dsh[VW-2:0], 1'b0};
      div_q   <= {div_q[VW-2:0], div_ge};
    end
  end

`ifndef SYNTHESIS
  a_accept_starts : assert property (@(posedge clk) disable iff (rst)
    in_accept |=> running)
    else $error("accepted item did not start the sequencer");

  a_div_in_item : assert property (@(posedge clk) disable iff (rst)
    (div_cnt != '0) |-> running)
    else $error("divider active outside an item");

  a_retire_loads : assert property (@(posedge clk) disable iff (rst)
    retire |=> (m_tvalid && m_tdata == $past(res)))
    else $error("retired result not loaded into the output register");

  a_pc_range : assert property (@(posedge clk) disable iff (rst)
    running |-> (pc < plhs_pkg::PC_W'(plhs_pkg::PROG_LEN)))
    else $error("microcode address beyond the program");

  a_reset_idle : assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (!running && !m_tvalid))
    else $error("sequencer or output not empty after reset");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for pi_limiter_heun_step
// Sends init, predictor, corrector and unused-kind items over the input
// stream with random gaps and result back-pressure. A bit-exact Q8.24
// predictor of the PI controller gives the expected result of every item.
// Gains, limits and the time step are rewritten over APB between runs and
// read back.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam longint KI_THR = plhs_pkg::KI_EPS_INT;
  localparam int RANDOM_ITEMS = 900;
  localparam int LONG_HOLD = 400;
  localparam int STALL_LIMIT = 3000;

  typedef struct {
    plhs_pkg::kind_t kind;
    logic [31:0]     value;
    logic            keep_start;
  } ctl_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [plhs_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pi_limiter_heun_step u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  longint cfg_kp = 64'sd16777216;
  longint cfg_ki = 0;
  longint cfg_omax = 64'sd16777216;
  longint cfg_omin = -64'sd16777216;
  longint cfg_step = 64'sd83886;
  longint x_start = 0;
  longint x_next = 0;
  longint rate_pred = 0;

  ctl_item_t   pending[$];
  ctl_item_t   cur_item;
  logic [31:0] want_results[$];
  logic [31:0] want;

  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int holds_done = 0;
  int results_seen = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  int idle_cycles = 0;
  int out_errors = 0;
  int rb_errors = 0;
  int checked = 0;
  int items_done = 0;
  int settings_done = 0;
  int queued = 0;
  int kind_count[4] = '{0, 0, 0, 0};

  function automatic longint sat32(longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p, m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = (m + 64'sd8388608) >>> 24;
    return sat32((p < 0) ? -m : m);
  endfunction

  function automatic longint fx_div(longint n, longint d);
    longint mn, md, q, r;
    if (d == 0) return (n > 0) ? QMAX : ((n < 0) ? QMIN : 0);
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    q = (mn <<< 24) / md;
    r = (mn <<< 24) % md;
    if (r >= md - r) q++;
    return sat32(((n < 0) != (d < 0)) ? -q : q);
  endfunction

  function automatic longint clamped_rate(inout longint x, input longint vin);
    longint kin, tmax, tmin, r;
    if (cfg_ki < KI_THR) return 0;
    kin = fx_mul(cfg_kp, vin);
    tmax = sat32(cfg_omax - kin);
    tmin = sat32(cfg_omin - kin);
    if (x > tmax) x = tmax;
    if (x < tmin) x = tmin;
    r = fx_mul(cfg_ki, vin);
    if (r > 0 && x >= tmax) r = 0;
    if (r < 0 && x <= tmin) r = 0;
    return r;
  endfunction

  function automatic longint limited_out(longint x, longint vin);
    longint o;
    o = sat32(fx_mul(vin, cfg_kp) + x);
    if (o > cfg_omax) o = cfg_omax;
    if (o < cfg_omin) o = cfg_omin;
    return o;
  endfunction

  function automatic longint heun_step(ctl_item_t it);
    longint v, r1, res;
    v = longint'($signed(it.value));
    res = 0;
    case (it.kind)
      plhs_pkg::KIND_INIT: begin
        if (cfg_ki > KI_THR) begin
          x_start = v;
          res = 0;
        end else begin
          x_start = 0;
          res = fx_div(v, cfg_kp);
        end
        x_next = x_start;
        rate_pred = 0;
      end
      plhs_pkg::KIND_PRED: begin
        if (!it.keep_start) x_start = x_next;
        rate_pred = clamped_rate(x_start, v);
        res = limited_out(x_start, v);
        x_next = sat32(x_start + fx_mul(rate_pred, cfg_step));
      end
      plhs_pkg::KIND_CORR: begin
        r1 = clamped_rate(x_next, v);
        res = limited_out(x_next, v);
        x_next = sat32(x_start + fx_mul((rate_pred + r1) >>> 1, cfg_step));
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($urandom_range(0, 1 << 26)) - 32'(1 << 25);
      4, 5:       return 32'($urandom_range(0, 1 << 28)) - 32'(1 << 27);
      6, 7, 8:    return $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0: return plhs_pkg::SMAX;
          1: return plhs_pkg::SMIN;
          2: return 32'd1;
          3: return 32'hFFFF_FFFF;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        want_results.push_back(32'(heun_step(cur_item)));
        kind_count[cur_item.kind]++;
        items_done++;
      end
      if (s_tvalid && !s_tready) begin
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
        cur_item = pending.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= cur_item.value;
        s_tuser <= {cur_item.keep_start, cur_item.kind};
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        gap_left = send_calm ? 0 : $urandom_range(0, 16);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        stall_left = recv_calm ? 0 : $urandom_range(0, 16);
        if (pending.size() > 10 && ((holds_done == 0 && results_seen >= 200) ||
            (holds_done == 1 && results_seen >= 600))) begin
          hold_left = LONG_HOLD;
          holds_done++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (want_results.size() == 0) begin
        out_errors++;
        $display("%0t: result %h arrived with none expected", $time, m_tdata);
      end else begin
        want = want_results.pop_front();
        checked++;
        if (m_tdata !== want) begin
          out_errors++;
          $display("%0t: result mismatch, expected %h actual %h", $time, want, m_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                 STALL_LIMIT, want_results.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic reg_write(plhs_pkg::reg_idx_t idx, logic [31:0] val);
    logic [31:0] rb_want;
    rb_want = (idx == plhs_pkg::REG_STEP_SIZE) ? {1'b0, val[30:0]} : val;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= plhs_pkg::ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      plhs_pkg::REG_KP:      cfg_kp = longint'($signed(val));
      plhs_pkg::REG_KI:      cfg_ki = longint'($signed(val));
      plhs_pkg::REG_OUT_MAX: cfg_omax = longint'($signed(val));
      plhs_pkg::REG_OUT_MIN: cfg_omin = longint'($signed(val));
      default:               cfg_step = longint'({1'b0, val[30:0]});
    endcase
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== rb_want) begin
      rb_errors++;
      $display("%0t: readback of register %s, expected %h actual %h", $time, idx.name(),
               rb_want, prdata);
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_settings(logic [31:0] kp, logic [31:0] ki, logic [31:0] omax,
                                logic [31:0] omin, logic [31:0] step);
    reg_write(plhs_pkg::REG_KP, kp);
    reg_write(plhs_pkg::REG_KI, ki);
    reg_write(plhs_pkg::REG_OUT_MAX, omax);
    reg_write(plhs_pkg::REG_OUT_MIN, omin);
    reg_write(plhs_pkg::REG_STEP_SIZE, step);
    settings_done++;
  endtask

  task automatic queue_item(plhs_pkg::kind_t kind, logic [31:0] value, logic keep);
    ctl_item_t it;
    it.kind = kind;
    it.value = value;
    it.keep_start = keep;
    pending.push_back(it);
  endtask

  task automatic drain(int tail);
    while (!(pending.size() == 0 && !s_tvalid && want_results.size() == 0))
      @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic random_settings();
    logic [31:0] kp, ki, omax, omin, step, t;
    case ($urandom_range(0, 9))
      0:       kp = '0;
      1:       kp = plhs_pkg::SMAX;
      2:       kp = plhs_pkg::SMIN;
      3, 4:    kp = $urandom;
      default: kp = 32'($urandom_range(0, 1 << 27)) - 32'(1 << 26);
    endcase
    case ($urandom_range(0, 11))
      0:       ki = '0;
      1:       ki = plhs_pkg::KI_EPS;
      2:       ki = plhs_pkg::KI_EPS - 1;
      3:       ki = plhs_pkg::KI_EPS + 1;
      4:       ki = plhs_pkg::SMAX;
      5:       ki = $urandom;
      default: ki = 32'($urandom_range(1 << 20, 1 << 27));
    endcase
    omax = 32'($urandom_range(1 << 22, 1 << 26));
    omin = -32'($urandom_range(1 << 22, 1 << 26));
    case ($urandom_range(0, 9))
      0: begin
        t = omax;
        omax = omin;
        omin = t;
      end
      1: begin
        omax = plhs_pkg::SMAX;
        omin = plhs_pkg::SMIN;
      end
      2: begin
        omax = $urandom;
        omin = $urandom;
      end
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0:       step = '0;
      1:       step = 32'h7FFF_FFFF;
      2:       step = {1'b0, 31'($urandom)};
      default: step = 32'($urandom_range(1 << 16, 1 << 23));
    endcase
    apply_settings(kp, ki, omax, omin, step);
  endtask

  // A run starts with an init and then mostly predictor/corrector pairs around
  // a slowly moving input, so the integrator can wind into the limits.
  task automatic queue_run(int n);
    int left, pick;
    logic [31:0] bias, v;
    left = n - 1;
    bias = 32'($urandom_range(0, 1 << 26)) - 32'(1 << 25);
    queue_item(plhs_pkg::KIND_INIT, rand_value(), 1'($urandom_range(0, 1)));
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      v = $urandom_range(0, 1) ? bias + 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21)
                               : rand_value();
      if (pick < 78) begin
        queue_item(plhs_pkg::KIND_PRED, v, pick >= 70);
        queue_item(plhs_pkg::KIND_CORR, ($urandom_range(0, 3) == 0) ? rand_value() : v,
                   1'($urandom_range(0, 1)));
        left -= 2;
      end else begin
        if (pick < 84) queue_item(plhs_pkg::KIND_CORR, v, 1'($urandom_range(0, 1)));
        else if (pick < 89) queue_item(plhs_pkg::KIND_PRED, v, 1'($urandom_range(0, 1)));
        else if (pick < 93) queue_item(plhs_pkg::KIND_NONE, $urandom,
                                       1'($urandom_range(0, 1)));
        else queue_item(plhs_pkg::KIND_INIT, v, 1'($urandom_range(0, 1)));
        left--;
      end
      if ($urandom_range(0, 29) == 0) bias = rand_value();
    end
  endtask

  initial begin
    int n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    queue_item(plhs_pkg::KIND_INIT, plhs_pkg::SMAX, 1'b0);
    queue_item(plhs_pkg::KIND_INIT, plhs_pkg::SMIN, 1'b0);
    queue_item(plhs_pkg::KIND_INIT, 32'h0000_0000, 1'b0);
    queue_item(plhs_pkg::KIND_INIT, 32'h0180_0000, 1'b1);
    queue_item(plhs_pkg::KIND_PRED, plhs_pkg::SMAX, 1'b0);
    queue_item(plhs_pkg::KIND_CORR, plhs_pkg::SMIN, 1'b1);
    queue_item(plhs_pkg::KIND_NONE, 32'hA5A5_5A5A, 1'b1);
    queue_item(plhs_pkg::KIND_PRED, 32'h0080_0000, 1'b1);
    drain(8);

    apply_settings(32'h0000_0000, plhs_pkg::KI_EPS, 32'hFF00_0000, 32'h0100_0000,
                   32'h7FFF_FFFF);
    queue_item(plhs_pkg::KIND_INIT, 32'h0500_0000, 1'b0);
    queue_item(plhs_pkg::KIND_INIT, 32'hFB00_0000, 1'b0);
    queue_item(plhs_pkg::KIND_INIT, 32'h0000_0000, 1'b0);
    queue_item(plhs_pkg::KIND_PRED, 32'h0100_0000, 1'b0);
    queue_item(plhs_pkg::KIND_CORR, 32'hFF00_0000, 1'b0);
    queue_item(plhs_pkg::KIND_PRED, plhs_pkg::SMIN, 1'b1);
    queue_item(plhs_pkg::KIND_CORR, plhs_pkg::SMAX, 1'b0);
    drain(8);

    apply_settings(plhs_pkg::SMIN, plhs_pkg::SMAX, plhs_pkg::SMAX, plhs_pkg::SMIN,
                   32'h0000_0000);
    queue_item(plhs_pkg::KIND_INIT, plhs_pkg::SMAX, 1'b0);
    queue_item(plhs_pkg::KIND_PRED, plhs_pkg::SMAX, 1'b0);
    queue_item(plhs_pkg::KIND_CORR, plhs_pkg::SMIN, 1'b0);
    queue_item(plhs_pkg::KIND_PRED, 32'h0000_0000, 1'b0);
    queue_item(plhs_pkg::KIND_CORR, 32'h0000_0001, 1'b0);
    queue_item(plhs_pkg::KIND_INIT, plhs_pkg::SMIN, 1'b1);
    queue_item(plhs_pkg::KIND_PRED, 32'h0000_0001, 1'b1);
    drain(8);

    while (queued < RANDOM_ITEMS) begin
      random_settings();
      n = $urandom_range(50, 100);
      queue_run(n);
      queued += n;
      drain(8);
    end
    drain(80);

    $display("Checked %0d results from %0d items: %0d init, %0d predictor,",
             checked, items_done, kind_count[plhs_pkg::KIND_INIT],
             kind_count[plhs_pkg::KIND_PRED]);
    $display("%0d corrector and %0d unused; %0d register settings read back, %0d long stalls.",
             kind_count[plhs_pkg::KIND_CORR], kind_count[plhs_pkg::KIND_NONE],
             settings_done, holds_done);
    if (out_errors == 0 && rb_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
